// File: src/bam_pkg.sv
// ---------------------------------------------------------------------------
// bam_pkg
// Shared types and constants for the byte-addressed data memory.
// ---------------------------------------------------------------------------
`default_nettype none

package bam_pkg;

    // Default capacity in bytes
    localparam int MEM_BYTES_DEF = 4096;

    // Size register: width and reset value (in 16-byte lines)
    localparam int       SIZE_W     = 9;
    localparam bit [8:0] SIZE_RESET = 9'd256;

    // Value every byte holds after reset
    localparam bit [7:0] RESET_BYTE = 8'ha5;

    // Command codes
    localparam bit CMD_READ  = 1'b0;
    localparam bit CMD_WRITE = 1'b1;

    // Access width codes; the unused code acts as a word
    localparam bit [1:0] WIDTH_BYTE = 2'd0;
    localparam bit [1:0] WIDTH_HALF = 2'd1;
    localparam bit [1:0] WIDTH_WORD = 2'd2;

    // Register index taken from the configuration address
    localparam bit REG_SIZE = 1'b0;

    // Sign-extension test bits and fill masks
    localparam bit [31:0] SX_BYTE_BIT  = 32'h0000_0080;
    localparam bit [31:0] SX_BYTE_FILL = 32'hffff_ff00;
    localparam bit [31:0] SX_HALF_BIT  = 32'h0000_8000;
    localparam bit [31:0] SX_HALF_FILL = 32'hffff_0000;

    // Request payload
    typedef struct packed {
        logic        command;
        logic [1:0]  access_width;
        logic        sign_extend;
        logic [31:0] address;
        logic [31:0] write_data;
    } t_req;

    // Response payload
    typedef struct packed {
        logic [31:0] read_data;
        logic        out_of_range;
    } t_rsp;

endpackage

`default_nettype wire

// File: src/bam_ram.sv
// ---------------------------------------------------------------------------
// bam_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data that updates only when a read is enabled.
// ---------------------------------------------------------------------------
`default_nettype none

module bam_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 1024,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write, then registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: src/byte_addressed_data_memory.sv
// An accepted request passes through stage 1 and then the output register.
// Throughput: one request per cycle while o_req_stall is low; four byte-lane RAMs
// each see at most one byte of any access, so loads and stores never contend for
// a port. Reset: the size register returns to 256 lines and a fill pass writes
// 0xa5 to every byte, one row of four bytes a cycle, with o_req_stall held high;
// configuration writes are taken throughout.
// ---------------------------------------------------------------------------
// byte_addressed_data_memory
// Little-endian byte-addressed memory with byte, halfword and word access,
// optional sign extension and per-byte range checking against a size register.
// ---------------------------------------------------------------------------
`default_nettype none

module byte_addressed_data_memory
    import bam_pkg::*;
#(
    parameter int MEM_BYTES = MEM_BYTES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    // Request channel
    input  wire logic        i_req_valid,
    output logic             o_req_stall,
    input  wire t_req        i_req,

    // Response channel
    output logic             o_rsp_valid,
    input  wire logic        i_rsp_stall,
    output t_rsp             o_rsp,

    // Configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam int ROWS   = (MEM_BYTES + 3) / 4;
    localparam int ROW_W  = $clog2(ROWS);
    localparam int MEM_AW = $clog2(MEM_BYTES + 1);
    localparam int LIM_W  = (MEM_AW > SIZE_W + 4) ? MEM_AW : SIZE_W + 4;

    // Size register and configuration port
    logic [SIZE_W-1:0] r_size, n_size;
    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_SIZE);
    assign prdata = (paddr[2] == REG_SIZE) ? {{(32-SIZE_W){1'b0}}, r_size} : 32'd0;

    always_comb begin
        n_size = r_size;
        if (cfg_wr) begin
            n_size = pwdata[SIZE_W-1:0];
        end
    end

    // Byte limit: size in bytes, saturated at the capacity
    logic [LIM_W-1:0] lines_bytes;
    logic [LIM_W-1:0] limit;

    assign lines_bytes = LIM_W'({r_size, 4'b0000});
    assign limit = (lines_bytes > LIM_W'(MEM_BYTES)) ? LIM_W'(MEM_BYTES) : lines_bytes;

    // Fill pass after reset
    logic             r_clr_busy, n_clr_busy;
    logic [ROW_W-1:0] r_clr_row, n_clr_row;

    always_comb begin
        n_clr_busy = r_clr_busy;
        n_clr_row  = r_clr_row;
        if (r_clr_busy) begin
            if (r_clr_row == ROW_W'(ROWS - 1)) begin
                n_clr_busy = 1'b0;
            end else begin
                n_clr_row = r_clr_row + ROW_W'(1);
            end
        end
    end

    // Pipeline handshake
    logic r_s1_valid, n_s1_valid;
    logic r_rsp_valid, n_rsp_valid;
    logic out_block, s1_advance, req_accept;

    assign out_block   = r_rsp_valid && i_rsp_stall;
    assign s1_advance  = r_s1_valid && !out_block;
    assign o_req_stall = r_clr_busy || (r_s1_valid && out_block);
    assign req_accept  = i_req_valid && !o_req_stall;

    // Request decode: per-byte addresses, range checks and lane routing
    logic [31:0]      byte_addr  [4];
    logic [3:0]       in_range;
    logic [3:0]       used;
    logic [1:0]       lane_k     [4];
    logic [ROW_W-1:0] lane_row   [4];
    logic [3:0]       lane_we;
    logic [7:0]       lane_wdata [4];

    always_comb begin
        unique case (i_req.access_width)
            WIDTH_BYTE: used = 4'b0001;
            WIDTH_HALF: used = 4'b0011;
            default:    used = 4'b1111;
        endcase
        for (int k = 0; k < 4; k++) begin
            byte_addr[k] = i_req.address + 32'(k);
            in_range[k]  = byte_addr[k] < 32'(limit);
        end
        for (int j = 0; j < 4; j++) begin
            lane_k[j]     = 2'(j) - i_req.address[1:0];
            lane_row[j]   = byte_addr[lane_k[j]][ROW_W+1:2];
            lane_we[j]    = req_accept && (i_req.command == CMD_WRITE)
                            && used[lane_k[j]] && in_range[lane_k[j]];
            lane_wdata[j] = i_req.write_data[{lane_k[j], 3'b000} +: 8];
        end
    end

    // Byte-lane RAMs; the fill pass owns the write ports while it runs
    logic [7:0] lane_rdata [4];

    for (genvar g = 0; g < 4; g++) begin : g_lane
        bam_ram #(
            .WIDTH (8),
            .DEPTH (ROWS)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (r_clr_busy || lane_we[g]),
            .i_waddr (r_clr_busy ? r_clr_row : lane_row[g]),
            .i_wdata (r_clr_busy ? RESET_BYTE : lane_wdata[g]),
            .i_re    (req_accept),
            .i_raddr (lane_row[g]),
            .o_rdata (lane_rdata[g])
        );
    end

    // Stage 1: hold the request details while the RAM read is in flight
    logic       r_s1_cmd, n_s1_cmd;
    logic [1:0] r_s1_width, n_s1_width;
    logic       r_s1_sx, n_s1_sx;
    logic [1:0] r_s1_shift, n_s1_shift;
    logic [3:0] r_s1_keep, n_s1_keep;
    logic       r_s1_bad, n_s1_bad;

    always_comb begin
        n_s1_valid = r_s1_valid;
        n_s1_cmd   = r_s1_cmd;
        n_s1_width = r_s1_width;
        n_s1_sx    = r_s1_sx;
        n_s1_shift = r_s1_shift;
        n_s1_keep  = r_s1_keep;
        n_s1_bad   = r_s1_bad;
        if (req_accept) begin
            n_s1_valid = 1'b1;
            n_s1_cmd   = i_req.command;
            n_s1_width = i_req.access_width;
            n_s1_sx    = i_req.sign_extend;
            n_s1_shift = i_req.address[1:0];
            n_s1_keep  = used & in_range;
            n_s1_bad   = |(used & ~in_range);
        end else if (s1_advance) begin
            n_s1_valid = 1'b0;
        end
    end

    // Assemble the little-endian read value and sign-extend it on request; writes return zero
    logic [31:0] asm_data;

    always_comb begin
        logic [1:0] lane;
        asm_data = 32'd0;
        for (int k = 0; k < 4; k++) begin
            lane = r_s1_shift + 2'(k);
            asm_data[8*k +: 8] = r_s1_keep[k] ? lane_rdata[lane] : 8'd0;
        end
        if (r_s1_cmd == CMD_WRITE) begin
            asm_data = 32'd0;
        end else if (r_s1_sx) begin
            if ((r_s1_width == WIDTH_BYTE) && ((asm_data & SX_BYTE_BIT) != 32'd0)) begin
                asm_data = asm_data | SX_BYTE_FILL;
            end else if ((r_s1_width == WIDTH_HALF)
                         && ((asm_data & SX_HALF_BIT) != 32'd0)) begin
                asm_data = asm_data | SX_HALF_FILL;
            end
        end
    end

    // Output register: load on advance, drop once taken
    t_rsp r_rsp, n_rsp;

    always_comb begin
        n_rsp_valid = r_rsp_valid;
        n_rsp       = r_rsp;
        if (s1_advance) begin
            n_rsp_valid        = 1'b1;
            n_rsp.read_data    = asm_data;
            n_rsp.out_of_range = r_s1_bad;
        end else if (!i_rsp_stall) begin
            n_rsp_valid = 1'b0;
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size      <= SIZE_RESET;
            r_clr_busy  <= 1'b1;
            r_clr_row   <= '0;
            r_s1_valid  <= 1'b0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_size      <= n_size;
            r_clr_busy  <= n_clr_busy;
            r_clr_row   <= n_clr_row;
            r_s1_valid  <= n_s1_valid;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_s1_cmd   <= n_s1_cmd;
        r_s1_width <= n_s1_width;
        r_s1_sx    <= n_s1_sx;
        r_s1_shift <= n_s1_shift;
        r_s1_keep  <= n_s1_keep;
        r_s1_bad   <= n_s1_bad;
        r_rsp      <= n_rsp;
    end

endmodule

`default_nettype wire

// File: src/bam_checker.sv
// ---------------------------------------------------------------------------
// bam_checker
// Port-level checks for the byte-addressed data memory, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module bam_checker
    import bam_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_req_valid,
    input wire logic o_req_stall,
    input wire logic o_rsp_valid,
    input wire logic i_rsp_stall,
    input wire t_rsp o_rsp
);

    // Leave reset with no response and requests held off for the fill pass
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_req_stall && !o_rsp_valid))
        else $error("response or request path open right after reset");

    // A fresh response follows an accepted request
    a_rsp_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp_valid) |-> $past(i_req_valid && !o_req_stall, 2))
        else $error("response appeared without a matching request");

    // A stalled response holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && i_rsp_stall) |=> (o_rsp_valid && $stable(o_rsp)))
        else $error("stalled response dropped or changed");

endmodule

bind byte_addressed_data_memory bam_checker u_bam_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req_valid),
    .o_req_stall (o_req_stall),
    .o_rsp_valid (o_rsp_valid),
    .i_rsp_stall (i_rsp_stall),
    .o_rsp       (o_rsp)
);

`default_nettype wire
